### design/afe_pkg.sv
// Shared types and constants of the audio fade envelope block.
package afe_pkg;

  // Configuration port and register widths
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SHAPE_W   = 2;

  // Gain is Q16 with unity at bit 16; curve position t is 16 bits
  localparam int GAIN_W = 17;
  localparam int Q_W    = 16;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_FRAMES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_FRAMES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_SHAPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_SHAPE  = 3'd4;

  // Curve shape codes; the unused code behaves as linear
  localparam logic [SHAPE_W-1:0] SHAPE_LINEAR = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_SINE   = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 2'd2;

  // Quarter-wave sine table generation (elaboration time only)
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 12;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;       // input transaction taken this cycle
    logic check;        // evaluate fade windows, seed gain
    logic div_start;    // load the divider
    logic div_sel_out;  // divider operands: fade-out when set
    logic crv1;         // curve stage: square and table index
    logic crv2;         // curve stage: table read
    logic crv3;         // curve stage: select shape, take minimum
    logic shape_out;    // curve uses fade-out shape when set
    logic scale;        // multiply sample by gain
    logic out_load;     // move result into output register
  } afe_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_act;
    logic out_act;
    logic div_last;
    logic out_free;
  } afe_status_t;

endpackage

### design/afe_stream_if.sv
// Stream channel interfaces for fade envelope input and output samples.
interface afe_in_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          frame_last;

  modport source (output valid, sample_in, frame_last, input ready);
  modport sink   (input valid, sample_in, frame_last, output ready);
endinterface

interface afe_out_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          frame_last_out;
  logic                          beyond_end;

  modport source (output valid, sample_out, frame_last_out, beyond_end, input ready);
  modport sink   (input valid, sample_out, frame_last_out, beyond_end, output ready);
endinterface

### design/afe_div.sv
// Restoring divider, two quotient bits per cycle, for the fade position ratio.
module afe_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [afe_pkg::CFG_W-1:0] num,
  input  logic [afe_pkg::CFG_W-1:0] den,
  output logic                      last,
  output logic [afe_pkg::Q_W-1:0]   quot
);
  import afe_pkg::*;

  localparam int STEPS = Q_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [CFG_W-1:0] rem;
  logic [CFG_W-1:0] dvs;
  logic [Q_W-1:0]   q;

  logic [CFG_W:0]   r1;
  logic [CFG_W:0]   r2;
  logic             ge1;
  logic             ge2;
  logic [CFG_W-1:0] rem1;
  logic [CFG_W-1:0] rem2;

  // Two dependent shift-compare-subtract steps; numerator is below divisor
  always_comb begin
    r1   = {rem, 1'b0};
    ge1  = r1 >= {1'b0, dvs};
    rem1 = ge1 ? CFG_W'(r1 - {1'b0, dvs}) : r1[CFG_W-1:0];
    r2   = {rem1, 1'b0};
    ge2  = r2 >= {1'b0, dvs};
    rem2 = ge2 ? CFG_W'(r2 - {1'b0, dvs}) : r2[CFG_W-1:0];
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dvs <= den;
      q   <= '0;
    end else if (busy) begin
      rem <= rem2;
      q   <= {q[Q_W-3:0], ge1, ge2};
    end
  end

  assign last = busy && (cnt == CNT_W'(STEPS - 1));
  assign quot = q;

endmodule

### design/afe_datapath.sv
// Datapath: configuration, frame position, fade windows, gain curves and scaling.
module afe_datapath #(
  parameter int SAMPLE_BITS      = 24,
  parameter int FRAME_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [afe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afe_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          frame_last,
  input  afe_pkg::afe_cmd_t             cmd,
  output afe_pkg::afe_status_t          status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          frame_last_out,
  output logic                          beyond_end
);
  import afe_pkg::*;

  localparam int CW    = (FRAME_BITS > CFG_W) ? FRAME_BITS : CFG_W;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW    = Q_W + IDX_W;
  localparam int PRW   = SAMPLE_BITS + GAIN_W + 1;
  localparam longint unsigned DEPTH_L    = 64'(SINE_TABLE_DEPTH);
  localparam longint unsigned HALF_DEPTH = 64'(SINE_TABLE_DEPTH / 2);

  // Q16 sine of k * pi / (2 * depth), Taylor series in Q30, rounded to nearest
  function automatic logic [GAIN_W-1:0] sine_entry(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned s;
    x    = (k * HALF_PI_Q30 + HALF_DEPTH) / DEPTH_L;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n[0] == 1'b0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    s = (s + 64'd8192) >> 14;
    if (s > 64'(UNITY_GAIN)) begin
      s = 64'(UNITY_GAIN);
    end
    return s[GAIN_W-1:0];
  endfunction

  // Configuration registers and frame position
  logic [CFG_W-1:0]      total_frames;
  logic [CFG_W-1:0]      fade_in_frames;
  logic [CFG_W-1:0]      fade_out_frames;
  logic [SHAPE_W-1:0]    fade_in_shape;
  logic [SHAPE_W-1:0]    fade_out_shape;
  logic [FRAME_BITS-1:0] frame_pos;
  logic                  cfg_hit;

  // Item registers
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          flag_r;
  logic [CFG_W-1:0]              in_len;
  logic [CFG_W-1:0]              out_len;
  logic                          beyond_r;
  logic                          in_act;
  logic                          out_act;
  logic [CFG_W-1:0]              num_out;
  logic [GAIN_W-1:0]             gain;
  logic signed [SAMPLE_BITS-1:0] res_r;

  // Curve unit registers
  logic [2*Q_W-1:0]   sq;
  logic [IDX_W-1:0]   idx;
  logic [Q_W-1:0]     t_r;
  logic [SHAPE_W-1:0] shape_r;
  logic [GAIN_W-1:0]  rom_q;

  // Combinational helpers
  logic [CFG_W-1:0]      half;
  logic [CW-1:0]         f_w;
  logic [CW-1:0]         total_w;
  logic [CW-1:0]         num_out_w;
  logic [CFG_W-1:0]      out_start;
  logic [Q_W-1:0]        quot;
  logic                  div_last;
  logic [PW-1:0]         idx_prod;
  logic [GAIN_W-1:0]     crv_gain;
  logic signed [PRW-1:0] prod;
  logic [CFG_W-1:0]      div_num;
  logic [CFG_W-1:0]      div_den;

  logic [GAIN_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

  // Build the quarter-wave table; end points fixed at 0 and unity
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
    if (k == 0) begin : g_zero
      assign sine_rom[k] = '0;
    end else if (k == SINE_TABLE_DEPTH) begin : g_unity
      assign sine_rom[k] = UNITY_GAIN;
    end else begin : g_mid
      assign sine_rom[k] = sine_entry(64'(k));
    end
  end

  // Decode register writes; any known index restarts the clip
  always_comb begin
    case (cfg_index)
      REG_TOTAL_FRAMES, REG_FADE_IN_FRAMES, REG_FADE_OUT_FRAMES,
      REG_FADE_IN_SHAPE, REG_FADE_OUT_SHAPE: cfg_hit = cfg_we;
      default:                               cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames    <= CFG_W'(1);
      fade_in_frames  <= '0;
      fade_out_frames <= '0;
      fade_in_shape   <= SHAPE_LINEAR;
      fade_out_shape  <= SHAPE_LINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOTAL_FRAMES:    total_frames    <= cfg_wdata;
        REG_FADE_IN_FRAMES:  fade_in_frames  <= cfg_wdata;
        REG_FADE_OUT_FRAMES: fade_out_frames <= cfg_wdata;
        REG_FADE_IN_SHAPE:   fade_in_shape   <= cfg_wdata[SHAPE_W-1:0];
        REG_FADE_OUT_SHAPE:  fade_out_shape  <= cfg_wdata[SHAPE_W-1:0];
        default:             total_frames    <= total_frames;
      endcase
    end
  end

  // Advance the frame position after the last channel of a frame; saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= '0;
    end else if (cfg_hit) begin
      frame_pos <= '0;
    end else if (cmd.out_load && flag_r && (frame_pos != '1)) begin
      frame_pos <= frame_pos + FRAME_BITS'(1);
    end
  end

  assign half      = total_frames >> 1;
  assign f_w       = CW'(frame_pos);
  assign total_w   = CW'(total_frames);
  assign out_start = total_frames - out_len;
  assign num_out_w = total_w - CW'(1) - f_w;

  // Capture the item, clamp fade lengths, flag frames past the end
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= sample_in;
      flag_r   <= frame_last;
      in_len   <= (fade_in_frames < half) ? fade_in_frames : half;
      out_len  <= (fade_out_frames < half) ? fade_out_frames : half;
      beyond_r <= f_w >= total_w;
    end
  end

  // Decide which fades apply and seed the gain
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      in_act  <= !beyond_r && (in_len != '0) && (f_w < CW'(in_len));
      out_act <= !beyond_r && (out_len != '0) && (f_w >= CW'(out_start));
      num_out <= num_out_w[CFG_W-1:0];
      gain    <= beyond_r ? '0 : UNITY_GAIN;
    end else if (cmd.crv3) begin
      gain <= (crv_gain < gain) ? crv_gain : gain;
    end
  end

  // Divider operands
  assign div_num = cmd.div_sel_out ? num_out : f_w[CFG_W-1:0];
  assign div_den = cmd.div_sel_out ? out_len : in_len;

  afe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .last  (div_last),
    .quot  (quot)
  );

  // Curve unit: square and table index, then table read, then shape select
  assign idx_prod = PW'(quot) * PW'(SINE_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.crv1) begin
      sq      <= (2*Q_W)'(quot) * (2*Q_W)'(quot);
      idx     <= idx_prod[PW-1:Q_W];
      t_r     <= quot;
      shape_r <= cmd.shape_out ? fade_out_shape : fade_in_shape;
    end
    if (cmd.crv2) begin
      rom_q <= sine_rom[idx];
    end
  end

  always_comb begin
    case (shape_r)
      SHAPE_SINE:   crv_gain = rom_q;
      SHAPE_SQUARE: crv_gain = GAIN_W'(sq[2*Q_W-1:Q_W]);
      default:      crv_gain = GAIN_W'(t_r);
    endcase
  end

  // Scale: floor(sample * gain / 65536)
  assign prod = $signed(sample_r) * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      res_r <= prod[SAMPLE_BITS+Q_W-1:Q_W];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_out     <= res_r;
      frame_last_out <= flag_r;
      beyond_end     <= beyond_r;
    end
  end

  assign status.in_act   = in_act;
  assign status.out_act  = out_act;
  assign status.div_last = div_last;
  assign status.out_free = !out_valid || out_ready;

  a_pos_monotone: assert property (@(posedge clk) disable iff (rst)
    !cfg_hit |=> frame_pos >= $past(frame_pos))
    else $error("frame position moved backward without a register write");

  a_beyond_silent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && beyond_end) |-> sample_out == '0)
    else $error("sample past the end of the clip is not silent");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scale |-> gain <= UNITY_GAIN)
    else $error("gain above unity at scaling");

endmodule

### design/afe_ctrl.sv
// Controller state machine sequencing one sample through the fade datapath.
module afe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  afe_pkg::afe_status_t status,
  output afe_pkg::afe_cmd_t    cmd
);
  import afe_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_SEL   = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_CRV1  = 9'b000010000,
    S_CRV2  = 9'b000100000,
    S_CRV3  = 9'b001000000,
    S_SCALE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   phase_out;
  logic   phase_out_next;

  // Next state and commands
  always_comb begin
    state_next      = state;
    phase_out_next  = phase_out;
    cmd             = '0;
    cmd.shape_out   = phase_out;
    in_ready        = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        phase_out_next = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        if (status.in_act) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else if (status.out_act) begin
          cmd.div_start   = 1'b1;
          cmd.div_sel_out = 1'b1;
          phase_out_next  = 1'b1;
          state_next      = S_DIV;
        end else begin
          state_next = S_SCALE;
        end
      end
      S_DIV: begin
        if (status.div_last) begin
          state_next = S_CRV1;
        end
      end
      S_CRV1: begin
        cmd.crv1   = 1'b1;
        state_next = S_CRV2;
      end
      S_CRV2: begin
        cmd.crv2   = 1'b1;
        state_next = S_CRV3;
      end
      S_CRV3: begin
        cmd.crv3 = 1'b1;
        if (!phase_out && status.out_act) begin
          cmd.div_start   = 1'b1;
          cmd.div_sel_out = 1'b1;
          phase_out_next  = 1'b1;
          state_next      = S_DIV;
        end else begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase_out <= 1'b0;
    end else begin
      state     <= state_next;
      phase_out <= phase_out_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an untaken output");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_last |-> state == S_DIV)
    else $error("divider finished while controller was not waiting on it");

endmodule

### design/audio_fade_envelope_unit.sv
// Audio fade envelope: one sample per transaction, scaled by a fade-in/out gain.
// When no fade applies a sample passes check, select, scale and done; when a fade applies
// it also takes a division and the curve steps, and when both fades apply it takes two of each.
// The next sample is taken once the result is loaded, which waits while the output is not taken.
// The shared restoring divider, 2 quotient bits per cycle, serves both fades in turn.
// Reset (rst, synchronous): registers take total 1, fades off, frame position 0.
module audio_fade_envelope_unit #(
  parameter int SAMPLE_BITS      = 24,
  parameter int FRAME_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  afe_in_if.sink                        in_ch,
  afe_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [afe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afe_pkg::CFG_W-1:0]     cfg_wdata
);
  import afe_pkg::*;

  afe_cmd_t    cmd;
  afe_status_t status;
  logic        in_ready;

  afe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  afe_datapath #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .FRAME_BITS       (FRAME_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .sample_in      (in_ch.sample_in),
    .frame_last     (in_ch.frame_last),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .sample_out     (out_ch.sample_out),
    .frame_last_out (out_ch.frame_last_out),
    .beyond_end     (out_ch.beyond_end)
  );

  assign in_ch.ready = in_ready;

endmodule
